// File: rtl/core/cursor_byte_buffer_with_crc32_unit_macros.svh
// assertion macros for the cursor byte buffer
`ifndef CURSOR_BYTE_BUFFER_WITH_CRC32_UNIT_MACROS_SVH
`define CURSOR_BYTE_BUFFER_WITH_CRC32_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CBB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cbb_pkg.sv
// shared types and constants for the cursor byte buffer
package cbb_pkg;

    localparam logic [2:0] REQ_WRITE     = 3'd0;
    localparam logic [2:0] REQ_READ      = 3'd1;
    localparam logic [2:0] REQ_FILL      = 3'd2;
    localparam logic [2:0] REQ_SET_READ  = 3'd3;
    localparam logic [2:0] REQ_SET_WRITE = 3'd4;
    localparam logic [2:0] REQ_APPEND    = 3'd5;
    localparam logic [2:0] REQ_CLEAR     = 3'd6;
    localparam logic [2:0] REQ_CRC       = 3'd7;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_READ_END = 2'd1;
    localparam logic [1:0] ERR_CURSOR   = 2'd2;
    localparam logic [1:0] ERR_CAPACITY = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  size_code;
        logic        sign_extend;
        logic [63:0] value;
        logic [12:0] position;
        logic [12:0] fill_count;
        logic [31:0] crc_seed;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [31:0] crc_value;
        logic [1:0]  error_code;
        logic [12:0] buffer_length;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ_ISSUE,
        ST_READ_WAIT,
        ST_CRC_ISSUE,
        ST_CRC_BIT,
        ST_DONE
    } state_t;

    // crc unit control
    typedef struct packed {
        logic load;
        logic feed;
        logic step;
    } crc_ctl_t;

endpackage

// File: rtl/core/cbb_crc_unit.sv
// bit-serial reflected crc-32 engine
module cbb_crc_unit (
    input  logic             clk,
    input  cbb_pkg::crc_ctl_t ctl,
    input  logic [31:0]      seed,
    input  logic [7:0]       data,
    output logic [31:0]      crc
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    // load seed, xor a byte in, or shift one bit
    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.load)
        begin
            crc_next = seed ^ cbb_pkg::CRC_INIT;
        end
        else if (ctl.feed)
        begin
            crc_next = crc_reg ^ {24'd0, data};
        end
        else if (ctl.step)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ cbb_pkg::CRC_POLY) : (crc_reg >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg ^ cbb_pkg::CRC_INIT;

endmodule

// File: rtl/core/cursor_byte_buffer_with_crc32_unit.sv
// top level of the cursor byte buffer with crc-32
//
// channel  | handshake          | payload
// request  | start / busy       | req (cbb_pkg::req_t)
// response | done strobe        | rsp (cbb_pkg::rsp_t)
// config   | apb psel / penable | big_endian at address 0
//
// write and fill store their bytes one at a time; read issues and waits on
// each byte, as the byte memory read is registered; crc issues, xors and makes
// eight shifts for each valid byte. cursor, append and clear take effect when
// the request is accepted; a rejected write, fill or read never writes the store.
// reset clears state, cursors, length and counters; the store is not cleared.
// the receiver cannot stall, and done is high for one cycle per transaction.
`include "cursor_byte_buffer_with_crc32_unit_macros.svh"

module cursor_byte_buffer_with_crc32_unit #(
    parameter int CAPACITY = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cbb_pkg::req_t   req,
    output logic            done,
    output cbb_pkg::rsp_t   rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic            paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    // storage
    logic [7:0] mem [CAPACITY];
    logic [7:0] rd_byte_reg;

    cbb_pkg::state_t state_reg, state_next;
    cbb_pkg::req_t   req_reg;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   rpos_reg, rpos_next;
    logic [LW-1:0]   wpos_reg, wpos_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic [LW-1:0]   cnt_reg, cnt_next;
    logic [2:0]      bit_reg, bit_next;
    logic [63:0]     acc_reg, acc_next;
    logic [1:0]      err_reg, err_next;
    logic            be_reg;
    logic            crc_mode_reg, crc_mode_next;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [7:0]      mem_wd;
    logic [AW-1:0]   mem_ra;
    logic [31:0]     crc_out;
    cbb_pkg::crc_ctl_t crc_ctl;
    logic [3:0]      nbytes;
    logic [LW:0]     room;
    logic [3:0]      lane;
    logic [7:0]      wr_byte;
    logic [63:0]     ext;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == 1'b0)
        begin
            be_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {31'd0, be_reg} : 32'd0;

    // byte memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_byte_reg <= mem[mem_ra];
    end

    cbb_crc_unit u_crc (
        .clk  (clk),
        .ctl  (crc_ctl),
        .seed (req.crc_seed),
        .data (rd_byte_reg),
        .crc  (crc_out)
    );

    assign nbytes = 4'd1 << req_reg.size_code;
    assign room   = (LW+1)'(CAPACITY) - {1'b0, wpos_reg};
    // byte lane within the value for the current index
    assign lane    = be_reg ? (nbytes - 4'd1 - cnt_reg[3:0]) : cnt_reg[3:0];
    assign wr_byte = (req_reg.req_type == cbb_pkg::REQ_FILL) ? req_reg.value[7:0]
                   : req_reg.value[{lane[2:0], 3'b000} +: 8];

    // sign extension of the assembled read
    always_comb
    begin
        ext = acc_reg;
        if (req_reg.sign_extend)
        begin
            case (req_reg.size_code)
                2'd0: ext = {{56{acc_reg[7]}}, acc_reg[7:0]};
                2'd1: ext = {{48{acc_reg[15]}}, acc_reg[15:0]};
                2'd2: ext = {{32{acc_reg[31]}}, acc_reg[31:0]};
                default: ext = acc_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cbb_pkg::ST_DONE;
                    case (req.req_type)
                        cbb_pkg::REQ_WRITE, cbb_pkg::REQ_FILL:
                            state_next = cbb_pkg::ST_WRITE;
                        cbb_pkg::REQ_READ:
                            state_next = cbb_pkg::ST_READ_ISSUE;
                        cbb_pkg::REQ_CRC:
                            state_next = cbb_pkg::ST_CRC_ISSUE;
                        default:
                            state_next = cbb_pkg::ST_DONE;
                    endcase
                end
            end
            cbb_pkg::ST_WRITE:
            begin
                if (err_reg != cbb_pkg::ERR_OK || cnt_reg == idx_reg)
                begin
                    state_next = cbb_pkg::ST_DONE;
                end
            end
            cbb_pkg::ST_READ_ISSUE:
            begin
                if (err_reg != cbb_pkg::ERR_OK)
                begin
                    state_next = cbb_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cbb_pkg::ST_READ_WAIT;
                end
            end
            cbb_pkg::ST_READ_WAIT:
            begin
                if (cnt_reg + LW'(1) == idx_reg)
                begin
                    state_next = cbb_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cbb_pkg::ST_READ_ISSUE;
                end
            end
            cbb_pkg::ST_CRC_ISSUE:
            begin
                if (cnt_reg == len_reg)
                begin
                    state_next = cbb_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cbb_pkg::ST_CRC_BIT;
                end
            end
            cbb_pkg::ST_CRC_BIT:
            begin
                if (crc_mode_reg && bit_reg == 3'd7)
                begin
                    state_next = cbb_pkg::ST_CRC_ISSUE;
                end
            end
            cbb_pkg::ST_DONE:
                state_next = cbb_pkg::ST_IDLE;
            default:
                state_next = cbb_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        len_next      = len_reg;
        rpos_next     = rpos_reg;
        wpos_next     = wpos_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        crc_mode_next = crc_mode_reg;
        mem_we        = 1'b0;
        mem_wa        = AW'(wpos_reg + cnt_reg);
        mem_wd        = wr_byte;
        mem_ra        = AW'(rpos_reg + cnt_reg);
        crc_ctl       = '0;
        case (state_reg)
            cbb_pkg::ST_IDLE:
            begin
                cnt_next      = '0;
                bit_next      = '0;
                acc_next      = '0;
                err_next      = cbb_pkg::ERR_OK;
                crc_mode_next = 1'b0;
                crc_ctl.load  = start;
                case (req.req_type)
                    cbb_pkg::REQ_WRITE:
                    begin
                        idx_next = LW'(4'd1 << req.size_code);
                        if ({1'b0, LW'(4'd1 << req.size_code)} > room)
                        begin
                            err_next = cbb_pkg::ERR_CAPACITY;
                        end
                    end
                    cbb_pkg::REQ_FILL:
                    begin
                        idx_next = LW'(req.fill_count);
                        if ({1'b0, LW'(req.fill_count)} > room ||
                            (LW < 13 && (req.fill_count >> LW) != 0))
                        begin
                            err_next = cbb_pkg::ERR_CAPACITY;
                        end
                    end
                    cbb_pkg::REQ_READ:
                    begin
                        idx_next = LW'(4'd1 << req.size_code);
                        if ((LW+1)'(rpos_reg) + (LW+1)'(4'd1 << req.size_code) >
                            (LW+1)'(len_reg))
                        begin
                            err_next = cbb_pkg::ERR_READ_END;
                        end
                    end
                    cbb_pkg::REQ_SET_READ:
                    begin
                        if ({3'd0, req.position} > 16'(len_reg))
                        begin
                            err_next = cbb_pkg::ERR_CURSOR;
                        end
                        else if (start)
                        begin
                            rpos_next = LW'(req.position);
                        end
                    end
                    cbb_pkg::REQ_SET_WRITE:
                    begin
                        if ({3'd0, req.position} > 16'(len_reg))
                        begin
                            err_next = cbb_pkg::ERR_CURSOR;
                        end
                        else if (start)
                        begin
                            wpos_next = LW'(req.position);
                        end
                    end
                    cbb_pkg::REQ_APPEND:
                    begin
                        if (start)
                        begin
                            wpos_next = len_reg;
                        end
                    end
                    cbb_pkg::REQ_CLEAR:
                    begin
                        if (start)
                        begin
                            len_next  = '0;
                            rpos_next = '0;
                            wpos_next = '0;
                        end
                    end
                    default:
                        idx_next = '0;
                endcase
            end
            cbb_pkg::ST_WRITE:
            begin
                if (err_reg == cbb_pkg::ERR_OK)
                begin
                    if (cnt_reg != idx_reg)
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + LW'(1);
                    end
                    else
                    begin
                        wpos_next = wpos_reg + idx_reg;
                        if (wpos_reg + idx_reg > len_reg)
                        begin
                            len_next = wpos_reg + idx_reg;
                        end
                    end
                end
            end
            cbb_pkg::ST_READ_ISSUE:
            begin
                mem_ra = AW'(rpos_reg + cnt_reg);
            end
            cbb_pkg::ST_READ_WAIT:
            begin
                acc_next[{lane[2:0], 3'b000} +: 8] = rd_byte_reg;
                cnt_next = cnt_reg + LW'(1);
                if (cnt_reg + LW'(1) == idx_reg)
                begin
                    rpos_next = rpos_reg + idx_reg;
                end
            end
            cbb_pkg::ST_CRC_ISSUE:
            begin
                mem_ra        = AW'(cnt_reg);
                crc_mode_next = 1'b0;
                bit_next      = '0;
            end
            cbb_pkg::ST_CRC_BIT:
            begin
                if (!crc_mode_reg)
                begin
                    crc_ctl.feed  = 1'b1;
                    crc_mode_next = 1'b1;
                end
                else
                begin
                    crc_ctl.step = 1'b1;
                    bit_next     = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        cnt_next = cnt_reg + LW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // state, cursors and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cbb_pkg::ST_IDLE;
            len_reg      <= '0;
            rpos_reg     <= '0;
            wpos_reg     <= '0;
            err_reg      <= cbb_pkg::ERR_OK;
            crc_mode_reg <= 1'b0;
            cnt_reg      <= '0;
            bit_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            rpos_reg     <= rpos_next;
            wpos_reg     <= wpos_next;
            err_reg      <= err_next;
            crc_mode_reg <= crc_mode_next;
            cnt_reg      <= cnt_next;
            bit_reg      <= bit_next;
            idx_reg      <= idx_next;
        end
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    // response
    assign busy = (state_reg != cbb_pkg::ST_IDLE);
    assign done = (state_reg == cbb_pkg::ST_DONE);
    always_comb
    begin
        rsp.read_data = '0;
        rsp.crc_value = '0;
        rsp.error_code = err_reg;
        rsp.buffer_length = 13'(len_reg);
        if (req_reg.req_type == cbb_pkg::REQ_READ && err_reg == cbb_pkg::ERR_OK)
        begin
            rsp.read_data = ext;
        end
        if (req_reg.req_type == cbb_pkg::REQ_CRC)
        begin
            rsp.crc_value = crc_out;
        end
    end

    `CBB_ASSERT_IMPL(a_len_cap, 1'b1, len_reg <= LW'(CAPACITY), "length past capacity")
    `CBB_ASSERT_IMPL(a_cursor_len, state_reg == cbb_pkg::ST_IDLE,
        rpos_reg <= len_reg && wpos_reg <= len_reg, "cursor past length")
    `CBB_ASSERT_NEXT(a_done_idle, done, !busy, "done not followed by idle")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the cursor byte buffer with crc-32
`timescale 1ns / 1ps

module testbench;

    localparam int STORE_BYTES = 4096;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    cbb_pkg::req_t req;
    logic          done;
    cbb_pkg::rsp_t rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic          paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // shadow copy of the buffer state
    logic [7:0]  shadow_store [STORE_BYTES];
    logic [12:0] shadow_length;
    logic [12:0] shadow_rd_cursor;
    logic [12:0] shadow_wr_cursor;
    logic        shadow_big_endian;

    cbb_pkg::rsp_t expected_rsp_q [$];
    int          mismatch_count;
    int          sent_count;
    int          checked_count;
    int          crc_count;
    int          burst_left;

    cursor_byte_buffer_with_crc32_unit #(.CAPACITY(STORE_BYTES)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // crc-32 over the valid bytes, continuing from a seed
    function automatic logic [31:0] buffer_crc(input logic [31:0] seed);
        logic [31:0] c;
        c = seed ^ cbb_pkg::CRC_INIT;
        for (int i = 0; i < shadow_length; i++)
        begin
            c ^= {24'd0, shadow_store[i]};
            for (int b = 0; b < 8; b++)
                c = c[0] ? ((c >> 1) ^ cbb_pkg::CRC_POLY) : (c >> 1);
        end
        return c ^ cbb_pkg::CRC_INIT;
    endfunction

    // apply one command to the shadow state and return its response
    function automatic cbb_pkg::rsp_t buffer_apply(input cbb_pkg::req_t r);
        cbb_pkg::rsp_t o;
        int          n;
        int          sh;
        logic [63:0] sign;
        n = 1 << r.size_code;
        o = '0;
        o.error_code = cbb_pkg::ERR_OK;
        case (r.req_type)
            cbb_pkg::REQ_WRITE:
            begin
                if (shadow_wr_cursor + n > STORE_BYTES)
                    o.error_code = cbb_pkg::ERR_CAPACITY;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        sh = shadow_big_endian ? 8 * (n - 1 - i) : 8 * i;
                        shadow_store[shadow_wr_cursor + i] = r.value[sh +: 8];
                    end
                    shadow_wr_cursor = 13'(shadow_wr_cursor + n);
                    if (shadow_wr_cursor > shadow_length)
                        shadow_length = shadow_wr_cursor;
                end
            end
            cbb_pkg::REQ_READ:
            begin
                if (shadow_rd_cursor + n > shadow_length)
                    o.error_code = cbb_pkg::ERR_READ_END;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        sh = shadow_big_endian ? 8 * (n - 1 - i) : 8 * i;
                        o.read_data[sh +: 8] = shadow_store[shadow_rd_cursor + i];
                    end
                    if (r.sign_extend && n < 8)
                    begin
                        sign = 64'd1 << (8 * n - 1);
                        if ((o.read_data & sign) != 0)
                            o.read_data |= ~((sign << 1) - 64'd1);
                    end
                    shadow_rd_cursor = 13'(shadow_rd_cursor + n);
                end
            end
            cbb_pkg::REQ_FILL:
            begin
                if (shadow_wr_cursor + r.fill_count > STORE_BYTES)
                    o.error_code = cbb_pkg::ERR_CAPACITY;
                else
                begin
                    for (int i = 0; i < r.fill_count; i++)
                        shadow_store[shadow_wr_cursor + i] = r.value[7:0];
                    shadow_wr_cursor += r.fill_count;
                    if (shadow_wr_cursor > shadow_length)
                        shadow_length = shadow_wr_cursor;
                end
            end
            cbb_pkg::REQ_SET_READ:
            begin
                if (r.position > shadow_length)
                    o.error_code = cbb_pkg::ERR_CURSOR;
                else
                    shadow_rd_cursor = r.position;
            end
            cbb_pkg::REQ_SET_WRITE:
            begin
                if (r.position > shadow_length)
                    o.error_code = cbb_pkg::ERR_CURSOR;
                else
                    shadow_wr_cursor = r.position;
            end
            cbb_pkg::REQ_APPEND:
                shadow_wr_cursor = shadow_length;
            cbb_pkg::REQ_CLEAR:
            begin
                shadow_length = '0;
                shadow_rd_cursor = '0;
                shadow_wr_cursor = '0;
            end
            default:
                o.crc_value = buffer_crc(r.crc_seed);
        endcase
        o.buffer_length = shadow_length;
        return o;
    endfunction

    // send one command, with a random gap before it
    task automatic send_cmd(input cbb_pkg::req_t r);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 30) == 0)
                burst_left = 30;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_rsp_q = {expected_rsp_q, buffer_apply(r)};
        sent_count++;
        if (r.req_type == cbb_pkg::REQ_CRC)
            crc_count++;
    endtask

    // build a command from its fields
    function automatic cbb_pkg::req_t make_cmd(input logic [2:0] kind, input logic [1:0] sz,
                                               input logic sx, input logic [63:0] val,
                                               input logic [12:0] pos, input logic [12:0] cnt,
                                               input logic [31:0] seed);
        cbb_pkg::req_t r;
        r.req_type    = kind;
        r.size_code   = sz;
        r.sign_extend = sx;
        r.value       = val;
        r.position    = pos;
        r.fill_count  = cnt;
        r.crc_seed    = seed;
        return r;
    endfunction

    // let all outstanding responses arrive, then settle
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // apb write of the byte order register; only while idle
    task automatic write_byte_order(input logic be);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= {31'd0, be};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        shadow_big_endian = be;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // response checker
    always @(posedge clk)
    begin
        cbb_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                checked_count++;
                if (rsp.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, rsp.read_data);
                    mismatch_count++;
                end
                if (rsp.crc_value !== want.crc_value)
                begin
                    $display("%0t: crc_value expected %h actual %h",
                             $time, want.crc_value, rsp.crc_value);
                    mismatch_count++;
                end
                if (rsp.error_code !== want.error_code)
                begin
                    $display("%0t: error_code expected %0d actual %0d",
                             $time, want.error_code, rsp.error_code);
                    mismatch_count++;
                end
                if (rsp.buffer_length !== want.buffer_length)
                begin
                    $display("%0t: buffer_length expected %0d actual %0d",
                             $time, want.buffer_length, rsp.buffer_length);
                    mismatch_count++;
                end
            end
        end
    end

    // typed writes and reads of every size, both extensions, error cases
    task automatic test_typed_access();
        logic [63:0] pattern;
        pattern = 64'h8899AABBCCDDEEFF;
        for (int s = 0; s < 4; s++)
            send_cmd(make_cmd(cbb_pkg::REQ_WRITE, s[1:0], 1'b0, pattern, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_WRITE, 2'd3, 1'b0, 64'hFFFFFFFFFFFFFFFF, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_WRITE, 2'd3, 1'b0, 64'h0, '0, '0, '0));
        for (int s = 0; s < 4; s++)
            send_cmd(make_cmd(cbb_pkg::REQ_READ, s[1:0], 1'b1, '0, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_SET_READ, 2'd0, 1'b0, '0, 13'd0, '0, '0));
        for (int s = 0; s < 4; s++)
            send_cmd(make_cmd(cbb_pkg::REQ_READ, s[1:0], 1'b0, '0, '0, '0, '0));
        // eight-byte read inside the data, then read cursor past end
        send_cmd(make_cmd(cbb_pkg::REQ_READ, 2'd3, 1'b1, '0, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_SET_READ, 2'd0, 1'b0, '0, 13'h1FFF, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_SET_WRITE, 2'd0, 1'b0, '0, 13'd3, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_FILL, 2'd0, 1'b0, 64'hA5, '0, 13'd0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_FILL, 2'd0, 1'b0, 64'h5A, '0, 13'd5, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_APPEND, 2'd0, 1'b0, '0, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_CRC, 2'd0, 1'b0, '0, '0, '0, 32'h0));
        send_cmd(make_cmd(cbb_pkg::REQ_CRC, 2'd0, 1'b0, '0, '0, '0, 32'hFFFFFFFF));
        send_cmd(make_cmd(cbb_pkg::REQ_CLEAR, 2'd0, 1'b0, '0, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_CRC, 2'd0, 1'b0, '0, '0, '0, 32'h12345678));
    endtask

    // full buffer: capacity overflow and cursors at the very end
    task automatic test_full_buffer();
        send_cmd(make_cmd(cbb_pkg::REQ_FILL, 2'd0, 1'b0, 64'hC3, '0, 13'd4096, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_WRITE, 2'd0, 1'b0, 64'h11, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_FILL, 2'd0, 1'b0, 64'h11, '0, 13'd1, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_SET_WRITE, 2'd0, 1'b0, '0, 13'd4088, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_WRITE, 2'd3, 1'b0, 64'hDEADBEEFCAFEF00D, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_SET_READ, 2'd0, 1'b0, '0, 13'd4088, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_READ, 2'd3, 1'b0, '0, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_READ, 2'd0, 1'b0, '0, '0, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_SET_READ, 2'd0, 1'b0, '0, 13'd4096, '0, '0));
        send_cmd(make_cmd(cbb_pkg::REQ_CRC, 2'd0, 1'b0, '0, '0, '0, 32'hA5A5A5A5));
        send_cmd(make_cmd(cbb_pkg::REQ_CLEAR, 2'd0, 1'b0, '0, '0, '0, '0));
    endtask

    // random command mix, mostly in range so cursors move through data
    task automatic test_random_mix(input int count);
        cbb_pkg::req_t r;
        int          pick;
        logic [12:0] cur_len;
        for (int k = 0; k < count; k++)
        begin
            cur_len = shadow_length;
            r = make_cmd(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), {$urandom, $urandom},
                         13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                         $urandom);
            pick = $urandom_range(0, 99);
            if (cur_len > 512 && pick < 50)
                r.req_type = cbb_pkg::REQ_CLEAR;
            else if (pick < 30)
                r.req_type = cbb_pkg::REQ_WRITE;
            else if (pick < 60)
                r.req_type = cbb_pkg::REQ_READ;
            else if (pick < 68)
            begin
                r.req_type = cbb_pkg::REQ_FILL;
                if ($urandom_range(0, 49) != 0)
                    r.fill_count = 13'($urandom_range(0, 24));
            end
            else if (pick < 76)
            begin
                r.req_type = cbb_pkg::REQ_SET_READ;
                if ($urandom_range(0, 9) != 0)
                    r.position = 13'($urandom_range(0, cur_len));
            end
            else if (pick < 84)
            begin
                r.req_type = cbb_pkg::REQ_SET_WRITE;
                if ($urandom_range(0, 9) != 0)
                    r.position = 13'($urandom_range(0, cur_len));
            end
            else if (pick < 89)
                r.req_type = cbb_pkg::REQ_APPEND;
            else if (pick < 92)
                r.req_type = cbb_pkg::REQ_CLEAR;
            else if (pick < 98)
                r.req_type = (cur_len > 512) ? cbb_pkg::REQ_CLEAR : cbb_pkg::REQ_CRC;
            // remaining picks keep the random opcode
            if (r.req_type == cbb_pkg::REQ_CRC && cur_len > 512)
                r.req_type = cbb_pkg::REQ_CLEAR;
            send_cmd(r);
        end
    endtask

    // timeout
    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        mismatch_count = 0;
        sent_count = 0;
        checked_count = 0;
        crc_count = 0;
        burst_left = 0;
        shadow_length = '0;
        shadow_rd_cursor = '0;
        shadow_wr_cursor = '0;
        shadow_big_endian = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_typed_access();
        wait_idle();
        write_byte_order(1'b1);
        test_typed_access();
        test_full_buffer();
        wait_idle();
        write_byte_order(1'b0);
        test_random_mix(270);
        wait_idle();
        write_byte_order(1'b1);
        test_random_mix(270);
        wait_idle();
        write_byte_order(1'b0);
        test_random_mix(270);
        wait_idle();
        write_byte_order(1'b1);
        test_random_mix(270);
        wait_idle();

        $display("ran %0d commands (%0d crc) in both byte orders, %0d responses checked",
                 sent_count, crc_count, checked_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cbb_pkg.sv
rtl/core/cbb_crc_unit.sv
rtl/core/cursor_byte_buffer_with_crc32_unit.sv
tb/sv/testbench.sv
